@@ sv/zce_pkg.sv @@
// Package for the zero crossing and extremum finder.
// Holds the transaction structs, result codes and limits; no dependencies.
`timescale 1ns / 1ps
package zce_pkg;

  localparam int SampleW = 32;
  localparam int StepW   = 20;
  localparam int CountW  = 21;

  localparam logic [CountW-1:0] COUNT_MAX = CountW'(1) << StepW;
  localparam logic [StepW-1:0]  STEP_MAX  = '1;

  localparam logic [1:0] KIND_MIN  = 2'd0;
  localparam logic [1:0] KIND_MAX  = 2'd1;
  localparam logic [1:0] KIND_XING = 2'd2;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_x;
    logic signed [SampleW-1:0] sample_y;
    logic                      end_of_series;
  } sample_t;

  typedef struct packed {
    logic                      channel;
    logic [1:0]                kind;
    logic [StepW-1:0]          step_index;
    logic signed [SampleW-1:0] coord_x;
    logic signed [SampleW-1:0] coord_y;
    logic                      last_of_run;
  } point_t;

  // What one lane found for one channel at one sample.
  typedef struct packed {
    logic xing;       // crossing to emit
    logic xing_next;  // crossing lies toward the following sample
    logic ext;        // strict extremum
    logic ext_max;    // extremum is a maximum
  } find_t;

  typedef struct packed {
    logic                      start;
    logic signed [SampleW-1:0] a;
    logic signed [SampleW-1:0] b;
    logic signed [SampleW-1:0] v1;
    logic signed [SampleW-1:0] v2;
  } interp_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SampleW-1:0] value;
  } interp_rsp_t;

endpackage

@@ sv/zce_lane.sv @@
// One search lane: crossing and extremum tests for one channel at one sample.
// Depends on zce_pkg.
`timescale 1ns / 1ps
module zce_lane (
  input  logic                              has_p,
  input  logic                              has_n,
  input  logic signed [zce_pkg::SampleW-1:0] pv,
  input  logic signed [zce_pkg::SampleW-1:0] cv,
  input  logic signed [zce_pkg::SampleW-1:0] nv,
  output zce_pkg::find_t                    find
);

  logic signed [zce_pkg::SampleW:0] s_pc, d_pc, s_cn, d_cn;
  logic np_pc, np_cn;

  function automatic logic nonpos(input logic signed [zce_pkg::SampleW-1:0] a,
                                  input logic signed [zce_pkg::SampleW-1:0] b);
    return (a <= 0 && b >= 0) || (a >= 0 && b <= 0);
  endfunction

  always_comb begin
    s_pc  = {pv[zce_pkg::SampleW-1], pv} + {cv[zce_pkg::SampleW-1], cv};
    d_pc  = {pv[zce_pkg::SampleW-1], pv} - {cv[zce_pkg::SampleW-1], cv};
    s_cn  = {cv[zce_pkg::SampleW-1], cv} + {nv[zce_pkg::SampleW-1], nv};
    d_cn  = {cv[zce_pkg::SampleW-1], cv} - {nv[zce_pkg::SampleW-1], nv};
    np_pc = has_p && nonpos(pv, cv);
    np_cn = has_n && nonpos(cv, nv);
    find  = '0;
    // A crossing with the predecessor shadows the one with the successor.
    if (np_pc) begin
      find.xing = (pv != cv) && (s_pc != 0) && (s_pc[zce_pkg::SampleW] == d_pc[zce_pkg::SampleW]);
    end else if (np_cn) begin
      find.xing = (cv != nv) && (s_cn != 0) && (s_cn[zce_pkg::SampleW] != d_cn[zce_pkg::SampleW]);
      find.xing_next = 1'b1;
    end
    if (has_p && has_n) begin
      if (cv < pv && cv < nv) begin
        find.ext = 1'b1;
      end else if (cv > pv && cv > nv) begin
        find.ext     = 1'b1;
        find.ext_max = 1'b1;
      end
    end
  end

endmodule

@@ sv/zce_interp.sv @@
// Shared interpolation unit: a + (b-a)*v1/(v1-v2), rounded half away from zero.
// One multiply, then a restoring divider one quotient bit per cycle. Depends on zce_pkg.
`timescale 1ns / 1ps
module zce_interp (
  input  logic                 clk,
  input  logic                 rst,
  input  zce_pkg::interp_req_t req,
  output zce_pkg::interp_rsp_t rsp
);

  localparam int W    = zce_pkg::SampleW;
  localparam int NumW = 2 * W;

  typedef enum logic [2:0] {I_IDLE, I_MUL, I_PREP, I_DIV, I_RND} istate_t;

  istate_t                state;
  logic signed [W:0]      diff, den;
  logic signed [W-1:0]    a_l, v1_l;
  logic signed [NumW:0]   num;
  logic [NumW-1:0]        quo;
  logic [W:0]             ud;
  logic [W+1:0]           rem;
  logic                   neg;
  logic [5:0]             cnt;

  logic [W+1:0]           rem_sh;
  logic                   ge;
  logic [NumW:0]          num_abs;
  logic [W:0]             den_abs;
  logic [W+2:0]           rem2;
  logic [W+1:0]           q_rnd;
  logic [W+1:0]           q_sgn;

  always_comb begin
    rem_sh  = {rem[W:0], quo[NumW-1]};
    ge      = rem_sh >= {1'b0, ud};
    num_abs = num[NumW] ? -num : num;
    den_abs = den[W] ? -den : den;
    rem2    = {rem, 1'b0};
    q_rnd   = quo[W+1:0] + ((rem2 >= {2'b00, ud}) ? (W+2)'(1) : (W+2)'(0));
    q_sgn   = neg ? -q_rnd : q_rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= I_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        I_IDLE: begin
          if (req.start) begin
            diff  <= {req.b[W-1], req.b} - {req.a[W-1], req.a};
            den   <= {req.v1[W-1], req.v1} - {req.v2[W-1], req.v2};
            a_l   <= req.a;
            v1_l  <= req.v1;
            state <= I_MUL;
          end
        end
        I_MUL: begin
          num   <= diff * v1_l;
          state <= I_PREP;
        end
        I_PREP: begin
          quo   <= num_abs[NumW-1:0];
          ud    <= den_abs;
          neg   <= num[NumW] ^ den[W];
          rem   <= '0;
          cnt   <= '0;
          state <= I_DIV;
        end
        I_DIV: begin
          rem <= ge ? rem_sh - {1'b0, ud} : rem_sh;
          quo <= {quo[NumW-2:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(NumW - 1)) begin
            state <= I_RND;
          end
        end
        I_RND: begin
          rsp.value <= a_l + q_sgn[W-1:0];
          rsp.done  <= 1'b1;
          state     <= I_IDLE;
        end
        default: state <= I_IDLE;
      endcase
    end
  end

endmodule

@@ sv/zero_crossing_extrema_finder.sv @@
// Top level of the zero crossing and extremum finder.
// Uses zce_pkg, zce_lane (four search lanes) and zce_interp (shared interpolator).
`timescale 1ns / 1ps
// Each sample transaction is taken while the block is idle; four lanes (two channels,
// at the held sample and, on end of series, at the last sample) test all candidates
// in the accept cycle, and the merging sequencer then walks eight result slots, one
// slot per cycle unless a crossing is being interpolated or the output stalls. An
// extremum is loaded straight from its slot; a crossing goes through the shared
// interpolator twice (x, then y) before it is emitted. The final result may
// still wait in the output register while the next sample is accepted.
module zero_crossing_extrema_finder (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  zce_pkg::sample_t sample,
  output logic             point_valid,
  input  logic             point_stall,
  output zce_pkg::point_t  point
);

  localparam int W = zce_pkg::SampleW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIVX, S_DIVY, S_EMIT} state_t;

  state_t                  state;
  logic signed [W-1:0]     win0 [2];
  logic signed [W-1:0]     win1 [2];
  logic [zce_pkg::CountW-1:0] count;

  // Held context of the transaction being worked on.
  logic signed [W-1:0]     hp0 [2];
  logic signed [W-1:0]     hp1 [2];
  logic signed [W-1:0]     hs  [2];
  logic [zce_pkg::CountW-1:0] k_l;
  zce_pkg::find_t          find_l [4];
  logic [7:0]              mask;
  logic [2:0]              slot;
  logic signed [W-1:0]     cx;
  logic signed [W-1:0]     cy;

  logic signed [W-1:0]     s_in [2];
  zce_pkg::find_t          find [4];
  logic [7:0]              mask_next;
  logic                    accept, out_free;

  assign s_in[0]      = sample.sample_x;
  assign s_in[1]      = sample.sample_y;
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !point_valid || !point_stall;

  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam int Ch = j % 2;
    if (j < 2) begin : g_held
      zce_lane u_lane (
        .has_p (count >= zce_pkg::CountW'(2)),
        .has_n (1'b1),
        .pv    (win1[Ch]),
        .cv    (win0[Ch]),
        .nv    (s_in[Ch]),
        .find  (find[j])
      );
    end else begin : g_last
      zce_lane u_lane (
        .has_p (count >= zce_pkg::CountW'(1)),
        .has_n (1'b0),
        .pv    (win0[Ch]),
        .cv    (s_in[Ch]),
        .nv    (s_in[Ch]),
        .find  (find[j])
      );
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic act;
      act = (j < 2) ? (count != '0) : sample.end_of_series;
      mask_next[2*j]   = act && find[j].xing;
      mask_next[2*j+1] = act && find[j].ext;
    end
  end

  // Merge side: decode the current slot.
  logic [1:0]              cur_j;
  logic                    cur_ch, cur_present, cur_ext, cur_last;
  zce_pkg::find_t          cur_find;
  logic signed [W-1:0]     pt_p [2];
  logic signed [W-1:0]     pt_c [2];
  logic signed [W-1:0]     pt_a [2];
  logic signed [W-1:0]     pt_b [2];
  logic [zce_pkg::CountW-1:0] idx;
  logic [zce_pkg::StepW-1:0]  idx_sat;
  logic [7:0]              low_mask;
  zce_pkg::interp_req_t    div_req;
  zce_pkg::interp_rsp_t    div_rsp;
  logic                    in_div;
  logic                    load;

  always_comb begin
    cur_j       = slot[2:1];
    cur_ch      = cur_j[0];
    cur_ext     = slot[0];
    cur_present = mask[slot];
    cur_find    = find_l[cur_j];
    low_mask    = (8'd2 << slot) - 8'd1;
    cur_last    = (mask & ~low_mask) == 8'd0;
    for (int c = 0; c < 2; c++) begin
      pt_p[c] = cur_j[1] ? hp0[c] : hp1[c];
      pt_c[c] = cur_j[1] ? hs[c]  : hp0[c];
      pt_a[c] = cur_find.xing_next ? pt_c[c] : pt_p[c];
      pt_b[c] = cur_find.xing_next ? hs[c]   : pt_c[c];
    end
    idx     = cur_j[1] ? k_l : k_l - zce_pkg::CountW'(1);
    idx_sat = (idx > zce_pkg::CountW'(zce_pkg::STEP_MAX)) ? zce_pkg::STEP_MAX
                                                          : idx[zce_pkg::StepW-1:0];
    in_div        = (state == S_DIVX);
    div_req.start = (state == S_SCAN && cur_present && !cur_ext) ||
                    (state == S_DIVX && div_rsp.done);
    div_req.a     = in_div ? pt_a[1] : pt_a[0];
    div_req.b     = in_div ? pt_b[1] : pt_b[0];
    div_req.v1    = pt_a[cur_ch];
    div_req.v2    = pt_b[cur_ch];
    // Load the output register with an extremum or a finished crossing.
    load          = out_free && ((state == S_SCAN && cur_present && cur_ext) ||
                                 state == S_EMIT);
  end

  zce_interp u_interp (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_valid <= 1'b0;
      count       <= '0;
      for (int c = 0; c < 2; c++) begin
        win0[c] <= '0;
        win1[c] <= '0;
      end
    end else begin
      if (load) begin
        point_valid <= 1'b1;
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            for (int c = 0; c < 2; c++) begin
              hp0[c] <= win0[c];
              hp1[c] <= win1[c];
              hs[c]  <= s_in[c];
            end
            for (int j = 0; j < 4; j++) begin
              find_l[j] <= find[j];
            end
            k_l   <= count;
            mask  <= mask_next;
            slot  <= '0;
            state <= S_SCAN;
            // Restart after the marked last sample, else shift the window.
            if (sample.end_of_series) begin
              count <= '0;
              for (int c = 0; c < 2; c++) begin
                win0[c] <= '0;
                win1[c] <= '0;
              end
            end else begin
              count <= (count >= zce_pkg::COUNT_MAX) ? zce_pkg::COUNT_MAX
                                                     : count + zce_pkg::CountW'(1);
              for (int c = 0; c < 2; c++) begin
                win1[c] <= win0[c];
                win0[c] <= s_in[c];
              end
            end
          end
        end
        S_SCAN: begin
          if (!cur_present) begin
            slot  <= slot + 3'd1;
            state <= (slot == 3'd7) ? S_IDLE : S_SCAN;
          end else if (!cur_ext) begin
            state <= S_DIVX;
          end else if (out_free) begin
            point.channel          <= cur_ch;
            point.kind             <= cur_find.ext_max ? zce_pkg::KIND_MAX
                                                       : zce_pkg::KIND_MIN;
            point.step_index       <= idx_sat;
            point.coord_x          <= pt_c[0];
            point.coord_y          <= pt_c[1];
            point.last_of_run      <= cur_last;
            slot                   <= slot + 3'd1;
            state                  <= (slot == 3'd7) ? S_IDLE : S_SCAN;
          end
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            cx    <= div_rsp.value;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            cy    <= div_rsp.value;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            point.channel    <= cur_ch;
            point.kind       <= zce_pkg::KIND_XING;
            point.step_index <= idx_sat;
            point.coord_x    <= cx;
            point.coord_y    <= cy;
            point.last_of_run <= cur_last;
            slot             <= slot + 3'd1;
            state            <= (slot == 3'd7) ? S_IDLE : S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVX || state == S_DIVY))
    else $error("interpolator finished outside a crossing");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SCAN)
    else $error("accepted sample did not start the slot walk");

  a_load_source: assert property (@(posedge clk) disable iff (rst)
    $rose(point_valid) |-> ($past(state) == S_SCAN || $past(state) == S_EMIT))
    else $error("result loaded from an unexpected state");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the zero crossing and extremum finder.
// Depends on zce_pkg and zero_crossing_extrema_finder; predicts points with a scoreboard class.
`timescale 1ns / 1ps
module tb_top;

  localparam longint LIMIT = 400000;

  // Tracks the sample window and the queue of expected points.
  class point_scoreboard;
    longint win_x[2];
    longint win_y[2];
    longint count;
    zce_pkg::point_t pending[$];
    int errors;
    int seen;

    function new();
      clear();
      errors = 0;
      seen = 0;
    endfunction

    function void clear();
      win_x[0] = 0; win_x[1] = 0;
      win_y[0] = 0; win_y[1] = 0;
      count = 0;
    endfunction

    // Round (b-a)*v1/(v1-v2) to nearest, ties away from zero, and add a.
    function longint lerp(longint a, longint b, longint v1, longint v2);
      longint num, den, un, ud, q, r;
      bit neg;
      num = (b - a) * v1;
      den = v1 - v2;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      q = un / ud;
      r = un % ud;
      if (r >= ud - r) q++;
      return a + (neg ? -q : q);
    endfunction

    function bit nonpos(longint a, longint b);
      return (a <= 0 && b >= 0) || (a >= 0 && b <= 0);
    endfunction

    function void add(bit ch, logic [1:0] k, longint idx, longint cx, longint cy);
      zce_pkg::point_t pt;
      pt.channel = ch;
      pt.kind = k;
      pt.step_index = idx > longint'(zce_pkg::STEP_MAX) ? zce_pkg::STEP_MAX
                                                        : idx[zce_pkg::StepW-1:0];
      pt.coord_x = cx[31:0];
      pt.coord_y = cy[31:0];
      pt.last_of_run = 1'b0;
      pending.insert(pending.size(), pt);
    endfunction

    function void search(bit ch, longint idx, bit has_p, longint px, longint py,
                         longint cx, longint cy, bit has_n, longint nx, longint ny);
      longint pv, cv, nv, s, d;
      pv = ch ? py : px;
      cv = ch ? cy : cx;
      nv = ch ? ny : nx;
      if (has_p && nonpos(pv, cv)) begin
        if (pv != cv) begin
          s = pv + cv; d = pv - cv;
          if (s != 0 && ((s < 0) == (d < 0)))
            add(ch, zce_pkg::KIND_XING, idx, lerp(px, cx, pv, cv), lerp(py, cy, pv, cv));
        end
      end else if (has_n && nonpos(cv, nv)) begin
        if (cv != nv) begin
          s = cv + nv; d = cv - nv;
          if (s != 0 && ((s < 0) != (d < 0)))
            add(ch, zce_pkg::KIND_XING, idx, lerp(cx, nx, cv, nv), lerp(cy, ny, cv, nv));
        end
      end
      if (has_p && has_n) begin
        if (cv < pv && cv < nv) add(ch, zce_pkg::KIND_MIN, idx, cx, cy);
        else if (cv > pv && cv > nv) add(ch, zce_pkg::KIND_MAX, idx, cx, cy);
      end
    endfunction

    function void note_sample(zce_pkg::sample_t smp);
      longint sx, sy, k;
      int before_n;
      sx = longint'(smp.sample_x);
      sy = longint'(smp.sample_y);
      k = count;
      before_n = pending.size();
      if (k >= 1)
        for (int ch = 0; ch < 2; ch++)
          search(ch[0], k - 1, k >= 2, win_x[1], win_y[1], win_x[0], win_y[0], 1'b1, sx, sy);
      if (smp.end_of_series) begin
        for (int ch = 0; ch < 2; ch++)
          search(ch[0], k, k >= 1, win_x[0], win_y[0], sx, sy, 1'b0, sx, sy);
        clear();
      end else begin
        win_x[1] = win_x[0]; win_x[0] = sx;
        win_y[1] = win_y[0]; win_y[0] = sy;
        count = k >= longint'(zce_pkg::COUNT_MAX) ? longint'(zce_pkg::COUNT_MAX) : k + 1;
      end
      if (pending.size() > before_n) pending[pending.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_point(zce_pkg::point_t got);
      zce_pkg::point_t exp_pt;
      seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected point %p", $time, got);
        errors++;
        return;
      end
      exp_pt = pending.pop_front();
      if (got !== exp_pt) begin
        $display("%0t: point mismatch expected %p actual %p", $time, exp_pt, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  zce_pkg::sample_t sample = '0;
  logic point_valid;
  logic point_stall = 1'b0;
  zce_pkg::point_t point;
  longint cycles = 0;
  int samples_sent = 0;
  int stall_mode = 0;
  point_scoreboard board = new();

  zero_crossing_extrema_finder dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .point_valid(point_valid), .point_stall(point_stall), .point(point)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Sample at the rising edge: note accepted transactions, check points.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (sample_valid && !sample_stall) board.note_sample(sample);
      if (point_valid && !point_stall) board.check_point(point);
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL zero_crossing_extrema_finder");
      $finish;
    end
  end

  // Receiver stalls on its own pattern, switching modes now and then.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: point_stall <= 1'b0;
      1: point_stall <= ($urandom_range(0, 3) == 0);
      2: point_stall <= ($urandom_range(0, 1) == 0);
      default: point_stall <= (cycles % 7) < 3;
    endcase
  end

  // Present one sample and hold it until taken.
  task automatic send(logic [31:0] sx, logic [31:0] sy, bit eos);
    sample <= '{sample_x: sx, sample_y: sy, end_of_series: eos};
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      sample_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 16);
    endcase
  endfunction

  initial begin
    int len, burst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, midpoint crossing, equal zeros, single sample, end cases.
    send(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send(32'hffff_ffff, 32'h0000_0001, 1'b1);
    send(32'd5, 32'd7, 1'b1);
    send(-32'sd4, 32'd0, 1'b0);
    send(32'd4, 32'd0, 1'b0);
    send(32'd0, 32'd0, 1'b0);
    send(32'd0, 32'd3, 1'b0);
    send(-32'sd3, -32'sd1, 1'b0);
    send(32'd10, 32'd9, 1'b1);
    send(32'd1, -32'sd5, 1'b0);
    send(32'd3, -32'sd1, 1'b0);
    send(32'd2, -32'sd6, 1'b0);
    send(-32'sd1, 32'd2, 1'b1);
    sample_valid <= 1'b0;

    // Random series of 1 to 12 samples in bursts.
    while (samples_sent < 120) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send(rand_value(), rand_value(), i == len - 1);
        gap();
      end
      burst = $urandom_range(0, 1);
      if (burst) begin
        sample_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    sample_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d samples in series of 1 to 12, checked %0d points", samples_sent,
             board.seen);
    $display("with random sender gaps and receiver stalls.");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS zero_crossing_extrema_finder");
    else
      $display("FAIL zero_crossing_extrema_finder");
    $finish;
  end
endmodule

@@ sim.f @@
sv/zce_pkg.sv
sv/zce_lane.sv
sv/zce_interp.sv
sv/zero_crossing_extrema_finder.sv
tb/tb_top.sv
